// ===== rtl/core/lsec_pkg.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor package
// Shared types, codes, color tables and sizes of the compositor.
// ----------------------------------------------------------------------------
package lsec_pkg;

    localparam int LED_COUNT  = 8;
    localparam int TIME_W     = 48;
    localparam int PIX_W      = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    localparam logic [15:0] TRI_DIV   = 16'd4000;
    localparam logic [15:0] WHEEL_DIV = 16'd3000;
    localparam int          DIV_STEPS = TIME_W / 4;

    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_LEVEL   = 3'd1;
    localparam logic [2:0] KIND_FLASH   = 3'd2;
    localparam logic [2:0] KIND_DANGER  = 3'd3;
    localparam logic [2:0] KIND_RAINBOW = 3'd4;
    localparam logic [2:0] KIND_WHITE   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TIME   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAINBOW_TIME = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_TIME   = 8'd3;

    localparam logic [2:0] LAST_BUTTON = 3'd4;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_color;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [2:0]        base_index;
        logic              danger;
        logic              flash_on;
        logic [2:0]        flash_button;
        logic              rainbow_on;
        logic              white_on;
    } t_frame_job;

    typedef struct packed {
        logic [3:0]  q;
        logic [11:0] r;
    } t_div_res;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } t_back_state;

    function automatic t_color level_color(input logic [2:0] idx);
        t_color c;
        case (idx)
            3'd0: c = '{8'd0, 8'd40, 8'd0};
            3'd1: c = '{8'd0, 8'd30, 8'd30};
            3'd2: c = '{8'd0, 8'd0, 8'd50};
            3'd3: c = '{8'd40, 8'd30, 8'd0};
            3'd4: c = '{8'd40, 8'd0, 8'd40};
            3'd5: c = '{8'd50, 8'd20, 8'd0};
            3'd6: c = '{8'd30, 8'd30, 8'd30};
            default: c = '{8'd50, 8'd0, 8'd0};
        endcase
        return c;
    endfunction

    function automatic t_color button_color(input logic [2:0] idx);
        t_color c;
        case (idx)
            3'd0: c = '{8'd120, 8'd118, 8'd120};
            3'd1: c = '{8'd255, 8'd227, 8'd49};
            3'd2: c = '{8'd40, 8'd160, 8'd20};
            3'd3: c = '{8'd20, 8'd60, 8'd255};
            3'd4: c = '{8'd220, 8'd20, 8'd70};
            default: c = '{8'd0, 8'd0, 8'd0};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/lsec_front.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor front end
// Holds the configuration and effect state, applies events and turns a
// frame request that is due into a frame job for the back end.
// ----------------------------------------------------------------------------
module lsec_front
    import lsec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [2:0]            i_kind,
    input  logic [TIME_W-1:0]     i_now_us,
    input  logic [7:0]            i_level,
    input  logic [2:0]            i_button,
    input  logic                  i_danger_on,
    output logic                  o_push,
    output t_frame_job            o_job
);

    logic [15:0]       r_frame_period;
    logic [19:0]       r_flash_time;
    logic [19:0]       r_rainbow_time;
    logic [19:0]       r_white_time;
    logic [2:0]        r_base_index;
    logic              r_danger;
    logic              r_flash_valid;
    logic [2:0]        r_flash_button;
    logic [TIME_W-1:0] r_flash_end;
    logic [TIME_W-1:0] r_rainbow_end;
    logic [TIME_W-1:0] r_white_end;
    logic [TIME_W-1:0] r_next_frame;

    logic [19:0]       effect_time;
    logic [TIME_W-1:0] effect_end;
    logic              frame_due;

    always_comb begin
        case (i_kind)
            KIND_FLASH:   effect_time = r_flash_time;
            KIND_RAINBOW: effect_time = r_rainbow_time;
            default:      effect_time = r_white_time;
        endcase
        effect_end = i_now_us + {{(TIME_W-20){1'b0}}, effect_time};
        frame_due  = i_now_us >= r_next_frame;
        o_push     = i_accept && (i_kind == KIND_FRAME) && frame_due;

        o_job.now          = i_now_us;
        o_job.base_index   = r_base_index;
        o_job.danger       = r_danger;
        o_job.flash_on     = r_flash_valid && (i_now_us < r_flash_end);
        o_job.flash_button = r_flash_button;
        o_job.rainbow_on   = i_now_us < r_rainbow_end;
        o_job.white_on     = i_now_us < r_white_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= 16'd16000;
            r_flash_time   <= 20'd150000;
            r_rainbow_time <= 20'd600000;
            r_white_time   <= 20'd300000;
            r_base_index   <= 3'd0;
            r_danger       <= 1'b0;
            r_flash_valid  <= 1'b0;
            r_flash_button <= 3'd0;
            r_flash_end    <= '0;
            r_rainbow_end  <= '0;
            r_white_end    <= '0;
            r_next_frame   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_PERIOD: r_frame_period <= i_cfg_data[15:0];
                    CFG_FLASH_TIME:   r_flash_time   <= i_cfg_data;
                    CFG_RAINBOW_TIME: r_rainbow_time <= i_cfg_data;
                    CFG_WHITE_TIME:   r_white_time   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                case (i_kind)
                    KIND_FRAME: begin
                        if (frame_due) begin
                            r_next_frame <= i_now_us + {{(TIME_W-16){1'b0}}, r_frame_period};
                        end
                    end
                    KIND_LEVEL: r_base_index <= i_level[2:0] - 3'd1;
                    KIND_FLASH: begin
                        if (i_button <= LAST_BUTTON) begin
                            r_flash_valid  <= 1'b1;
                            r_flash_button <= i_button;
                            r_flash_end    <= effect_end;
                        end
                    end
                    KIND_DANGER:  r_danger      <= i_danger_on;
                    KIND_RAINBOW: r_rainbow_end <= effect_end;
                    KIND_WHITE:   r_white_end   <= effect_end;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/lsec_queue.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor job queue
// Two-entry queue of frame jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module lsec_queue
    import lsec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_job i_job,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_frame_job o_job
);

    t_frame_job  r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

// ===== rtl/core/lsec_back.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor back end
// Derives the pulse and wheel phases of a frame job with a radix-16 divider
// and then emits one composed color per LED through an output register.
// ----------------------------------------------------------------------------
module lsec_back
    import lsec_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_frame_job       i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_pixel_index,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic             o_frame_end
);

    localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(LED_COUNT - 1);
    localparam logic [3:0]       LAST_STEP = 4'(DIV_STEPS - 1);

    function automatic t_div_res div_step(input logic [15:0] acc, input logic [15:0] dv);
        t_div_res   res;
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (acc >= 16'(k) * dv) begin
                q = 4'(k);
            end
        end
        res.q = q;
        res.r = 12'(acc - {12'd0, q} * dv);
        return res;
    endfunction

    t_back_state       r_state;
    t_back_state       n_state;
    t_frame_job        r_job;
    logic [TIME_W-1:0] r_shift;
    logic [11:0]       r_rem_tri;
    logic [11:0]       r_rem_wheel;
    logic [7:0]        r_q_tri;
    logic [7:0]        r_q_wheel;
    logic [3:0]        r_step;
    logic [PIX_W-1:0]  r_pix;
    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pix;
    t_color            r_out_color;
    logic              r_out_end;

    t_div_res          tri_res;
    t_div_res          wheel_res;
    logic              load_out;
    logic [7:0]        tri_val;
    logic [7:0]        pos;
    logic [7:0]        wq;
    logic [9:0]        wq3;
    logic [8:0]        seg;
    t_color            color;

    assign tri_res   = div_step({r_rem_tri, r_shift[TIME_W-1 -: 4]}, TRI_DIV);
    assign wheel_res = div_step({r_rem_wheel, r_shift[TIME_W-1 -: 4]}, WHEEL_DIV);
    assign load_out  = (r_state == BK_EMIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        tri_val = r_q_tri[7] ? 8'd255 - r_q_tri : r_q_tri;
        pos     = {r_pix[3:0], 4'd0} + r_q_wheel;
        seg     = ({3'd0, r_pix} * 9'd5) / 9'(LED_COUNT);

        color = level_color(r_job.base_index);
        if (r_job.danger) begin
            color = '{8'd60 + tri_val, 8'd0, 8'd0};
        end
        if (r_job.flash_on && (seg == {6'd0, r_job.flash_button})) begin
            color = button_color(r_job.flash_button);
        end
        if (pos < 8'd85) begin
            wq = pos;
        end else if (pos < 8'd170) begin
            wq = pos - 8'd85;
        end else begin
            wq = pos - 8'd170;
        end
        wq3 = {2'd0, wq} * 10'd3;
        if (r_job.rainbow_on) begin
            if (pos < 8'd85) begin
                color = '{8'd255 - wq3[7:0], wq3[7:0], 8'd0};
            end else if (pos < 8'd170) begin
                color = '{8'd0, 8'd255 - wq3[7:0], wq3[7:0]};
            end else begin
                color = '{wq3[7:0], 8'd0, 8'd255 - wq3[7:0]};
            end
        end
        if (r_job.white_on) begin
            color = '{8'd255, 8'd255, 8'd255};
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (load_out && (r_pix == LAST_PIX)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_job;
            r_shift     <= i_job.now;
            r_rem_tri   <= 12'd0;
            r_rem_wheel <= 12'd0;
            r_step      <= 4'd0;
        end
        if (r_state == BK_DIV) begin
            r_shift     <= {r_shift[TIME_W-5:0], 4'd0};
            r_rem_tri   <= tri_res.r;
            r_rem_wheel <= wheel_res.r;
            r_q_tri     <= {r_q_tri[3:0], tri_res.q};
            r_q_wheel   <= {r_q_wheel[3:0], wheel_res.q};
            r_step      <= r_step + 4'd1;
            r_pix       <= '0;
        end
        if (load_out) begin
            r_out_pix   <= r_pix;
            r_out_color <= color;
            r_out_end   <= r_pix == LAST_PIX;
            r_pix       <= r_pix + PIX_W'(1);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_index = r_out_pix;
    assign o_red         = r_out_color.r;
    assign o_green       = r_out_color.g;
    assign o_blue        = r_out_color.b;
    assign o_frame_end   = r_out_end;

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_end |-> r_out_pix == LAST_PIX)
        else $error("Frame end marked on a pixel other than the last one.");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_DIV |-> ({4'd0, r_rem_tri} < TRI_DIV) && ({4'd0, r_rem_wheel} < WHEEL_DIV))
        else $error("Divider remainder reached the divisor.");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == BK_IDLE) && i_job_valid)
        else $error("Job taken from the queue while the back end was busy or it was empty.");

    a_emit_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BK_EMIT |-> r_pix <= LAST_PIX)
        else $error("Pixel counter ran past the last LED.");

endmodule

// ===== rtl/core/led_strip_effect_compositor.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor
// Composes LED strip colors from a base level color and timed overlays.
// Events are accepted one per cycle while the two-entry job queue is not full.
// A frame request that renders is divided by the 48-bit time divider, four bits
// per step, and then one pixel per cycle follows while the output is not stalled.
// The back end takes the next queued job only once it has loaded its last pixel.
// Reset is synchronous and active low and restores the default settings.
// ----------------------------------------------------------------------------
module led_strip_effect_compositor
    import lsec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_kind,
    input  logic [TIME_W-1:0]     i_now_us,
    input  logic [7:0]            i_level,
    input  logic [2:0]            i_button,
    input  logic                  i_danger_on,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_index,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic                  o_frame_end
);

    logic       accept;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    t_frame_job front_job;
    t_frame_job back_job;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    lsec_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_kind      (i_kind),
        .i_now_us    (i_now_us),
        .i_level     (i_level),
        .i_button    (i_button),
        .i_danger_on (i_danger_on),
        .o_push      (push),
        .o_job       (front_job)
    );

    lsec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    lsec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (back_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_frame_end   (o_frame_end)
    );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// LED strip effect compositor testbench
// Sends a directed table of event and frame requests, then random phases under
// several register settings, with random idling on both channels and a long
// output hold-off. Every pixel is checked against a directed row's color or an
// in-bench model of layer composition, timed deadlines and frame rate limit.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lsec_pkg::*;

    localparam logic [2:0]  KIND_SPARE_LO   = 3'd6;
    localparam logic [2:0]  KIND_SPARE_HI   = 3'd7;
    localparam logic [47:0] DANGER_STEP_US  = 48'd4000;
    localparam logic [47:0] WHEEL_STEP_US   = 48'd3000;
    localparam int          SEGMENT_COUNT   = 5;
    localparam int          NUM_DIRECTED    = 25;
    localparam int          ITEMS_PER_PHASE = 76;
    localparam int          NUM_PHASES      = 6;
    localparam int          SETTLE_CYCLES   = 4 * (LED_COUNT + 16);
    localparam int          HOLD_CYCLES     = 400;
    localparam int          QUIET_LIMIT     = 3000;
    localparam int          MAX_REPORTS     = 100;

    typedef struct packed {
        logic [PIX_W-1:0] index;
        t_color           color;
        logic             last;
    } t_pixel;

    typedef struct {
        logic [2:0]  kind;
        logic [47:0] now;
        logic [7:0]  level;
        logic [2:0]  button;
        logic        danger_on;
        logic        typed;
        t_color      color;
    } t_request_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [2:0]            i_kind;
    logic [TIME_W-1:0]     i_now_us;
    logic [7:0]            i_level;
    logic [2:0]            i_button;
    logic                  i_danger_on;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [PIX_W-1:0]      o_pixel_index;
    logic [7:0]            o_red;
    logic [7:0]            o_green;
    logic [7:0]            o_blue;
    logic                  o_frame_end;

    logic   req_typed;
    t_color req_color;

    t_pixel pending_pixels [$];
    int     mismatch_count = 0;
    int     quiet_cycles = 0;
    int     send_gap_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_request = 1'b0;

    logic [15:0] cfg_period;
    logic [19:0] cfg_flash;
    logic [19:0] cfg_rainbow;
    logic [19:0] cfg_white;
    logic [2:0]  lvl_idx;
    logic        danger_st;
    logic        flash_armed;
    logic [2:0]  flash_btn;
    logic [47:0] flash_until;
    logic [47:0] rainbow_until;
    logic [47:0] white_until;
    logic [47:0] frame_due;

    t_color level_rgb [8] = '{
        '{8'd0, 8'd40, 8'd0}, '{8'd0, 8'd30, 8'd30}, '{8'd0, 8'd0, 8'd50},
        '{8'd40, 8'd30, 8'd0}, '{8'd40, 8'd0, 8'd40}, '{8'd50, 8'd20, 8'd0},
        '{8'd30, 8'd30, 8'd30}, '{8'd50, 8'd0, 8'd0}};
    t_color flash_rgb [SEGMENT_COUNT] = '{
        '{8'd120, 8'd118, 8'd120}, '{8'd255, 8'd227, 8'd49}, '{8'd40, 8'd160, 8'd20},
        '{8'd20, 8'd60, 8'd255}, '{8'd220, 8'd20, 8'd70}};

    t_request_row directed_rows [NUM_DIRECTED] = '{
        '{KIND_FRAME,   48'd0,       8'd0,   3'd0, 1'b0, 1'b1, '{8'd0, 8'd40, 8'd0}},
        '{KIND_FRAME,   48'd15999,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_LEVEL,   48'd15999,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd16000,   8'd0,   3'd0, 1'b0, 1'b1, '{8'd50, 8'd0, 8'd0}},
        '{KIND_LEVEL,   48'd16000,   8'd255, 3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_SPARE_LO, 48'd32000,  8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_SPARE_HI, 48'd32000,  8'd255, 3'd7, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FLASH,   48'd32000,   8'd0,   3'd7, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FLASH,   48'd32000,   8'd0,   3'd5, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd32000,   8'd0,   3'd0, 1'b0, 1'b1, '{8'd30, 8'd30, 8'd30}},
        '{KIND_FLASH,   48'd40000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd48000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FLASH,   48'd50000,   8'd0,   3'd4, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_DANGER,  48'd50000,   8'd0,   3'd0, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd64000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_RAINBOW, 48'd70000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd80000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_WHITE,   48'd90000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd96000,   8'd0,   3'd0, 1'b0, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{KIND_DANGER,  48'd96000,   8'd0,   3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_RAINBOW, 48'hFFFF_FFFF_FFFF, 8'd0, 3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_WHITE,   48'hFFFF_FFFF_FF9C, 8'd0, 3'd0, 1'b0, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'hFFFF_FFFF_FFFF, 8'd0, 3'd0, 1'b0, 1'b1, '{8'd30, 8'd30, 8'd30}},
        '{KIND_DANGER,  48'd0,       8'd0,   3'd0, 1'b1, 1'b0, '{8'd0, 8'd0, 8'd0}},
        '{KIND_FRAME,   48'd1532000, 8'd0,   3'd0, 1'b0, 1'b1, '{8'd187, 8'd0, 8'd0}}};

    wire request_taken = i_in_valid && !o_in_stall;
    wire pixel_taken   = o_out_valid && !i_out_stall;

    led_strip_effect_compositor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_now_us      (i_now_us),
        .i_level       (i_level),
        .i_button      (i_button),
        .i_danger_on   (i_danger_on),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_index (o_pixel_index),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_frame_end   (o_frame_end)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_color wheel_rgb(input logic [7:0] pos);
        logic [7:0] q;
        t_color     c;
        if (pos < 8'd85) begin
            q = pos;
            c = '{8'd255 - 8'd3 * q, 8'd3 * q, 8'd0};
        end else if (pos < 8'd170) begin
            q = pos - 8'd85;
            c = '{8'd0, 8'd255 - 8'd3 * q, 8'd3 * q};
        end else begin
            q = pos - 8'd170;
            c = '{8'd3 * q, 8'd0, 8'd255 - 8'd3 * q};
        end
        return c;
    endfunction

    function automatic void clear_model();
        cfg_period    = 16'd16000;
        cfg_flash     = 20'd150000;
        cfg_rainbow   = 20'd600000;
        cfg_white     = 20'd300000;
        lvl_idx       = 3'd0;
        danger_st     = 1'b0;
        flash_armed   = 1'b0;
        flash_btn     = 3'd0;
        flash_until   = '0;
        rainbow_until = '0;
        white_until   = '0;
        frame_due     = '0;
    endfunction

    // Updates the effect state for one request and queues the pixels of a
    // rendered frame, taking the typed color instead where the row gives one.
    function automatic void apply_request(input logic [2:0] kind, input logic [47:0] now,
                                          input logic [7:0] level, input logic [2:0] button,
                                          input logic danger_on, input logic typed,
                                          input t_color typed_color);
        t_pixel      pix;
        t_color      c;
        logic [47:0] slot;
        logic [7:0]  tri_lvl;
        case (kind)
            KIND_LEVEL: lvl_idx = 3'(level - 8'd1);
            KIND_FLASH: begin
                if (button <= LAST_BUTTON) begin
                    flash_armed = 1'b1;
                    flash_btn   = button;
                    flash_until = now + 48'(cfg_flash);
                end
            end
            KIND_DANGER:  danger_st = danger_on;
            KIND_RAINBOW: rainbow_until = now + 48'(cfg_rainbow);
            KIND_WHITE:   white_until = now + 48'(cfg_white);
            KIND_FRAME: begin
                if (now >= frame_due) begin
                    frame_due = now + 48'(cfg_period);
                    for (int i = 0; i < LED_COUNT; i++) begin
                        c = level_rgb[lvl_idx];
                        if (danger_st) begin
                            slot    = now / DANGER_STEP_US;
                            tri_lvl = slot[7:0];
                            if (tri_lvl > 8'd127) begin
                                tri_lvl = 8'd255 - tri_lvl;
                            end
                            c = '{8'd60 + tri_lvl, 8'd0, 8'd0};
                        end
                        if (now < flash_until && flash_armed
                            && (i * SEGMENT_COUNT / LED_COUNT) == int'(flash_btn)) begin
                            c = flash_rgb[flash_btn];
                        end
                        if (now < rainbow_until) begin
                            slot = now / WHEEL_STEP_US;
                            c    = wheel_rgb(slot[7:0] + 8'(i * 16));
                        end
                        if (now < white_until) begin
                            c = '{8'd255, 8'd255, 8'd255};
                        end
                        pix.index = PIX_W'(i);
                        pix.color = typed ? typed_color : c;
                        pix.last  = (i == LED_COUNT - 1);
                        pending_pixels.push_back(pix);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0d ns: mismatch: %s", $time, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (request_taken) begin
                apply_request(i_kind, i_now_us, i_level, i_button, i_danger_on,
                              req_typed, req_color);
            end
            if (pixel_taken) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch($sformatf("pixel %0d arrived with none expected",
                                              o_pixel_index));
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_index !== want.index || o_red !== want.color.r
                        || o_green !== want.color.g || o_blue !== want.color.b
                        || o_frame_end !== want.last) begin
                        report_mismatch($sformatf(
                            "got pixel %0d rgb %0d,%0d,%0d end %0b, expected %0d %0d,%0d,%0d end %0b",
                            o_pixel_index, o_red, o_green, o_blue, o_frame_end, want.index,
                            want.color.r, want.color.g, want.color.b, want.last));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || request_taken || pixel_taken) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_out_stall <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    task automatic send_request(input logic [2:0] kind, input logic [47:0] now,
                                input logic [7:0] level, input logic [2:0] button,
                                input logic danger_on, input logic typed, input t_color color);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_now_us    <= now;
        i_level     <= level;
        i_button    <= button;
        i_danger_on <= danger_on;
        req_typed   <= typed;
        req_color   <= color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_PERIOD: cfg_period  = data[15:0];
            CFG_FLASH_TIME:   cfg_flash   = data;
            CFG_RAINBOW_TIME: cfg_rainbow = data;
            CFG_WHITE_TIME:   cfg_white   = data;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [19:0] period, input logic [19:0] flash,
                                 input logic [19:0] rainbow, input logic [19:0] white);
        write_register(CFG_FRAME_PERIOD, period);
        write_register(CFG_FLASH_TIME, flash);
        write_register(CFG_RAINBOW_TIME, rainbow);
        write_register(CFG_WHITE_TIME, white);
        write_register(CFG_IDX_W'($urandom_range(int'(CFG_WHITE_TIME) + 1, 255)),
                       20'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [47:0] cur_time;
        logic [47:0] base;
        logic [47:0] now;
        logic [2:0]  kind;
        logic [2:0]  button;
        int          roll;
        int          counted;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= KIND_FRAME;
        i_now_us    <= '0;
        i_level     <= '0;
        i_button    <= '0;
        i_danger_on <= 1'b0;
        req_typed   <= 1'b0;
        req_color   <= '0;
        clear_model();
        send_gap_pct   = 16;
        recv_stall_pct = 76;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].kind, directed_rows[r].now, directed_rows[r].level,
                         directed_rows[r].button, directed_rows[r].danger_on,
                         directed_rows[r].typed, directed_rows[r].color);
        end

        cur_time = 48'd2000000;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            send_gap_pct   = (ph < 2) ? 16 : (ph < 4) ? 76 : 0;
            recv_stall_pct = (ph < 2) ? 76 : (ph < 4) ? 16 : 0;
            case (ph)
                0: load_settings(20'd1000, 20'd20000, 20'd50000, 20'd10000);
                1: load_settings(20'h30000, 20'd0, 20'd0, 20'd0);
                2: load_settings(20'h0FFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
                3: load_settings(20'($urandom()), 20'($urandom()), 20'($urandom()),
                                 20'($urandom()));
                4: load_settings(20'd300, 20'd5000, 20'd100000, 20'd2000);
                default: load_settings(20'($urandom_range(1, 3000)),
                                       20'($urandom_range(0, 400000)),
                                       20'($urandom_range(0, 400000)),
                                       20'($urandom_range(0, 400000)));
            endcase
            if (ph == NUM_PHASES - 1) begin
                // Start just below the top of the time range so that it can wrap.
                cur_time = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(20000, 200000));
            end else begin
                base = {3'(ph), 13'($urandom()), 32'($urandom())};
                if (base > cur_time) begin
                    cur_time = base;
                end
            end
            if (ph == 4) begin
                hold_request = 1'b1;
            end
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                roll     = $urandom_range(0, 99);
                cur_time = cur_time + 48'($urandom_range(0, int'(cfg_period) + 2000));
                if (roll < 46) begin
                    kind = KIND_FRAME;
                end else if (roll < 56) begin
                    kind = KIND_LEVEL;
                end else if (roll < 70) begin
                    kind = KIND_FLASH;
                end else if (roll < 78) begin
                    kind = KIND_DANGER;
                end else if (roll < 87) begin
                    kind = KIND_RAINBOW;
                end else if (roll < 95) begin
                    kind = KIND_WHITE;
                end else begin
                    kind = 3'($urandom_range(int'(KIND_SPARE_LO), int'(KIND_SPARE_HI)));
                end
                now = cur_time;
                if (kind != KIND_FRAME && $urandom_range(0, 99) < 5) begin
                    now = {16'($urandom()), 32'($urandom())};
                end
                button = 3'($urandom_range(0, 7));
                send_request(kind, now, 8'($urandom_range(0, 255)), button,
                             1'($urandom_range(0, 1)), 1'b0, '0);
                if (kind <= KIND_WHITE && !(kind == KIND_FLASH && button > LAST_BUTTON)) begin
                    counted++;
                end
            end
        end

        drain();
        if (pending_pixels.size() != 0) begin
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      pending_pixels.size()));
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
